FILE: hdl/peer_choke_scheduler_core_defines.svh
// Assertion macros shared by the peer choke scheduler RTL.
`ifndef PEER_CHOKE_SCHEDULER_CORE_DEFINES_SVH
`define PEER_CHOKE_SCHEDULER_CORE_DEFINES_SVH

// same-cycle implication
`define PCS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/pcs_pkg.sv
// Types and constants of the peer choke scheduler.
package pcs_pkg;

  localparam int TAG_W   = 16;
  localparam int RATE_W  = 32;
  localparam int TIME_W  = 48;
  localparam int SHUF_W  = 16;
  localparam int UT_W    = 7;
  localparam int SLOTS_W = 13;

  localparam int IN_TDATA_W  = 184;
  localparam int OUT_TDATA_W = 24;

  localparam logic [SLOTS_W-1:0] SLOTS_RESET     = 13'd4242;
  localparam logic [RATE_W-1:0]  ZERO_RATE_LIMIT = 32'd103;
  localparam logic [TIME_W:0]    HOLD_OPT_MS     = 49'd30000;
  localparam logic [TIME_W:0]    HOLD_CHG_MS     = 49'd10000;
  localparam logic [UT_W-1:0]    UT_MAX          = 7'd127;

  // register index as seen in paddr[2]
  localparam logic REG_UNCHOKE_SLOTS = 1'b0;

  typedef enum logic [2:0] {
    L_FIXED,
    L_CZ,
    L_CN,
    L_UZ,
    L_UN
  } list_e;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [RATE_W-1:0] rate;
    list_e             lst;
    logic              ou;
    logic              oo;
    logic              nu;
    logic              no;
  } rec_t;

  typedef struct packed {
    logic              store;
    rec_t              rec;
    logic              last;
    logic [SHUF_W-1:0] shuf_c;
    logic [SHUF_W-1:0] shuf_u;
    logic [UT_W-1:0]   ut;
    logic              optn;
  } qent_t;

endpackage

FILE: hdl/pcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pcs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/pcs_queue.sv
// Two-entry queue of classified peer records between front and back.
module pcs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pcs_pkg::qent_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pcs_pkg::qent_t out_data_o
);

  pcs_pkg::qent_t buf_q [2];
  logic           wp_q;
  logic           rp_q;
  logic [1:0]     cnt_q;
  logic           push;
  logic           pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = buf_q[rp_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= in_data_i;
    end
  end

endmodule

FILE: hdl/pcs_front.sv
// Front end: accepts peer records, applies the hold rules and classifies them.
module pcs_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_tvalid_i,
  output logic                               s_tready_o,
  input  logic [pcs_pkg::IN_TDATA_W-1:0]     s_tdata_i,
  input  logic                               s_tlast_i,
  output logic                               q_valid_o,
  input  logic                               q_ready_i,
  output pcs_pkg::qent_t                     q_data_o
);

  logic [pcs_pkg::TAG_W-1:0]  tag;
  logic                       conn;
  logic                       intr;
  logic                       wu;
  logic                       wo;
  logic [pcs_pkg::TIME_W-1:0] last_chg;
  logic [pcs_pkg::RATE_W-1:0] rate;
  logic [pcs_pkg::TIME_W-1:0] now;
  logic                       exp_opt;
  logic                       exp_chg;
  logic                       zero;
  logic                       opt;
  logic                       skip;
  logic                       inc;
  logic                       store;
  pcs_pkg::list_e             lst;
  logic                       nu;
  logic                       no;
  logic [pcs_pkg::UT_W-1:0]   ut_q;
  logic [pcs_pkg::UT_W-1:0]   ut_d;
  logic                       optn_q;
  logic                       optn_d;
  logic                       push;

  assign tag      = s_tdata_i[15:0];
  assign conn     = s_tdata_i[16];
  assign intr     = s_tdata_i[17];
  assign wu       = s_tdata_i[18];
  assign wo       = s_tdata_i[19];
  assign last_chg = s_tdata_i[67:20];
  assign rate     = s_tdata_i[99:68];
  assign now      = s_tdata_i[147:100];

  assign exp_opt = ({1'b0, last_chg} + pcs_pkg::HOLD_OPT_MS) < {1'b0, now};
  assign exp_chg = ({1'b0, last_chg} + pcs_pkg::HOLD_CHG_MS) < {1'b0, now};
  assign zero    = rate < pcs_pkg::ZERO_RATE_LIMIT;

  always_comb begin
    store  = 1'b0;
    lst    = pcs_pkg::L_FIXED;
    nu     = 1'b0;
    no     = 1'b0;
    inc    = 1'b0;
    opt    = wo;
    skip   = 1'b0;
    optn_d = optn_q;
    if (conn) begin
      if (!intr) begin
        store = wu;
      end else if (wu) begin
        if (wo) begin
          if (exp_opt) begin
            opt = 1'b0;
          end else begin
            optn_d = 1'b0;
            skip   = 1'b1;
          end
        end
        if (!skip) begin
          inc = 1'b1;
          if (exp_chg) begin
            store = 1'b1;
            lst   = zero ? pcs_pkg::L_CZ : pcs_pkg::L_CN;
            nu    = 1'b1;
            no    = opt;
          end else if (opt != wo) begin
            store = 1'b1;
            nu    = 1'b1;
            no    = opt;
          end
        end
      end else if (exp_chg) begin
        store = 1'b1;
        lst   = zero ? pcs_pkg::L_UZ : pcs_pkg::L_UN;
        no    = wo;
      end
    end
    ut_d = (inc && (ut_q != pcs_pkg::UT_MAX)) ? ut_q + 7'd1 : ut_q;
  end

  assign s_tready_o = q_ready_i;
  assign q_valid_o  = s_tvalid_i;
  assign push       = s_tvalid_i && q_ready_i;

  assign q_data_o.store    = store;
  assign q_data_o.rec.tag  = tag;
  assign q_data_o.rec.rate = rate;
  assign q_data_o.rec.lst  = lst;
  assign q_data_o.rec.ou   = wu;
  assign q_data_o.rec.oo   = wo;
  assign q_data_o.rec.nu   = nu;
  assign q_data_o.rec.no   = no;
  assign q_data_o.last     = s_tlast_i;
  assign q_data_o.shuf_c   = s_tdata_i[163:148];
  assign q_data_o.shuf_u   = s_tdata_i[179:164];
  assign q_data_o.ut       = ut_d;
  assign q_data_o.optn     = optn_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ut_q   <= '0;
      optn_q <= 1'b1;
    end else if (push) begin
      if (s_tlast_i) begin
        ut_q   <= '0;
        optn_q <= 1'b1;
      end else begin
        ut_q   <= ut_d;
        optn_q <= optn_d;
      end
    end
  end

endmodule

FILE: hdl/pcs_back.sv
// Back end: stores a pulse, ranks and rotates the lists, trades slots, emits changes.
module pcs_back #(
  parameter int MaxPeers = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_valid_i,
  output logic                               q_ready_o,
  input  pcs_pkg::qent_t                     q_data_i,
  input  logic [pcs_pkg::SLOTS_W-1:0]        slots_i,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  output logic [pcs_pkg::OUT_TDATA_W-1:0]    m_tdata_o,
  output logic                               m_tuser_o,
  output logic                               m_tlast_o
);

  localparam int AW = $clog2(MaxPeers);
  localparam int CW = $clog2(MaxPeers + 1);
  localparam int RW = $bits(pcs_pkg::rec_t);
  localparam logic [CW-1:0] CAP = CW'(MaxPeers);

  typedef enum logic [4:0] {
    S_LOAD, S_RI, S_RJ, S_RF, S_MOD, S_OPT, S_X1, S_X2, S_X3, S_X4,
    S_T5, S_T6A, S_T6C, S_T7, S_EA, S_EW, S_ED, S_EE
  } state_e;

  state_e         state_q;
  logic [CW-1:0]  cnt_q, na_q, nb_q, nc_q, nd_q;
  logic [CW-1:0]  a_rem_q, b_rem_q, c_rem_q, d_rem_q;
  logic [CW-1:0]  sc_q, su_q;
  logic [pcs_pkg::SHUF_W-1:0] shc_q, shu_q;
  logic           optn_q, optc_q, optd_q;
  logic signed [14:0] unch_q;
  logic [AW-1:0]  i_q, j_q, pj_q, rk_q;
  logic           pv_q;
  logic [3:0]     mstep_q;
  logic [CW-1:0]  mr_q;
  logic           msel_q;
  logic           pend_v_q, pend_u_q, pend_o_q;
  logic [pcs_pkg::TAG_W-1:0] pend_tag_q, cand_tag_q, otag_q;
  logic           cand_c_q, cand_u_q, cand_o_q;
  logic           ov_q, ouser_q, olast_q, ounch_q, oopt_q;

  pcs_pkg::rec_t  e_rec;
  pcs_pkg::rec_t  ra, rb;
  logic [RW-1:0]  ra_raw, rb_raw;
  logic [AW-1:0]  pos_rd;
  logic [pcs_pkg::RATE_W-1:0] cnr_rd, unr_rd;
  logic           pop, room, rec_we;
  logic           pos_we;
  logic [AW-1:0]  pos_waddr, pos_wdata;
  logic           cnr_we, unr_we;
  logic           hit;
  logic [AW-1:0]  rank_fin;
  logic [CW-1:0]  mod_n;
  logic           mod_bit;
  logic [CW:0]    mod_t;
  logic [CW-1:0]  mod_r_d;
  logic signed [14:0] slots_s, diff_over, want, avail_s;
  logic [CW-1:0]  avail, take;
  logic [CW-1:0]  p_ext, rot_c, rot_u;
  logic           cu, co, cchg;
  logic           out_free;
  logic           ov_set;
  logic           i_end;
  logic [CW-1:0]  min_ad, min_ac;
  logic           opt_c, opt_d;

  assign e_rec = q_data_i.rec;
  assign ra    = pcs_pkg::rec_t'(ra_raw);
  assign rb    = pcs_pkg::rec_t'(rb_raw);

  pcs_ram #(.Width(RW), .Depth(MaxPeers)) u_rec_a (
    .clk_i, .we_i(rec_we), .waddr_i(cnt_q[AW-1:0]), .wdata_i(e_rec),
    .raddr_i(i_q), .rdata_o(ra_raw)
  );
  pcs_ram #(.Width(RW), .Depth(MaxPeers)) u_rec_b (
    .clk_i, .we_i(rec_we), .waddr_i(cnt_q[AW-1:0]), .wdata_i(e_rec),
    .raddr_i(j_q), .rdata_o(rb_raw)
  );
  pcs_ram #(.Width(AW), .Depth(MaxPeers)) u_pos (
    .clk_i, .we_i(pos_we), .waddr_i(pos_waddr), .wdata_i(pos_wdata),
    .raddr_i(i_q), .rdata_o(pos_rd)
  );
  pcs_ram #(.Width(pcs_pkg::RATE_W), .Depth(MaxPeers)) u_cn_rate (
    .clk_i, .we_i(cnr_we), .waddr_i(rank_fin), .wdata_i(ra.rate),
    .raddr_i(AW'(b_rem_q - CW'(1))), .rdata_o(cnr_rd)
  );
  pcs_ram #(.Width(pcs_pkg::RATE_W), .Depth(MaxPeers)) u_un_rate (
    .clk_i, .we_i(unr_we), .waddr_i(rank_fin), .wdata_i(ra.rate),
    .raddr_i(AW'(d_rem_q - CW'(1))), .rdata_o(unr_rd)
  );

  assign q_ready_o = (state_q == S_LOAD);
  assign pop       = q_ready_o && q_valid_i;
  assign room      = cnt_q < CAP;
  assign rec_we    = pop && q_data_i.store && room;
  assign i_end     = (CW'(i_q) == cnt_q - CW'(1));
  assign out_free  = !ov_q || m_tready_i;
  assign ov_set    = ((state_q == S_ED) && cand_c_q && pend_v_q && out_free) ||
                     ((state_q == S_EE) && out_free);
  assign opt_c     = optn_q && (nc_q != '0);
  assign opt_d     = optn_q && (nc_q == '0) && (nd_q != '0);

  always_comb begin
    hit = 1'b0;
    if (pv_q && (rb.lst == ra.lst) && (pj_q != i_q)) begin
      if (ra.lst == pcs_pkg::L_CN) begin
        hit = (rb.rate > ra.rate) || ((rb.rate == ra.rate) && (pj_q < i_q));
      end else begin
        hit = (rb.rate < ra.rate) || ((rb.rate == ra.rate) && (pj_q < i_q));
      end
    end
    rank_fin = rk_q + AW'(hit);
    cnr_we   = (state_q == S_RF) && (ra.lst == pcs_pkg::L_CN);
    unr_we   = (state_q == S_RF) && (ra.lst == pcs_pkg::L_UN);
    pos_we    = 1'b0;
    pos_waddr = i_q;
    pos_wdata = rank_fin;
    if (rec_we && (e_rec.lst == pcs_pkg::L_CZ || e_rec.lst == pcs_pkg::L_UZ)) begin
      pos_we    = 1'b1;
      pos_waddr = cnt_q[AW-1:0];
      pos_wdata = (e_rec.lst == pcs_pkg::L_CZ) ? na_q[AW-1:0] : nc_q[AW-1:0];
    end else if (cnr_we || unr_we) begin
      pos_we = 1'b1;
    end
  end

  // shuffle reduction, one bit per cycle
  always_comb begin
    mod_n   = msel_q ? nc_q : na_q;
    mod_bit = msel_q ? shu_q[mstep_q] : shc_q[mstep_q];
    mod_t   = {mr_q, mod_bit};
    mod_r_d = (mod_t >= {1'b0, mod_n}) ? CW'(mod_t - {1'b0, mod_n}) : CW'(mod_t);
  end

  always_comb begin
    slots_s   = $signed({2'b00, slots_i});
    diff_over = unch_q - slots_s;
    case (state_q)
      S_X1:    avail = a_rem_q;
      S_X2:    avail = b_rem_q;
      S_X3:    avail = d_rem_q;
      default: avail = c_rem_q;
    endcase
    want    = (state_q == S_X1 || state_q == S_X2) ? diff_over : -diff_over;
    avail_s = $signed(15'(avail));
    if (want <= 15'sd0) begin
      take = '0;
    end else if (want > avail_s) begin
      take = avail;
    end else begin
      take = CW'(want);
    end
    min_ad = (a_rem_q < d_rem_q) ? a_rem_q : d_rem_q;
    min_ac = (a_rem_q < c_rem_q) ? a_rem_q : c_rem_q;
  end

  // decision of the entry at i_q
  always_comb begin
    p_ext = CW'(pos_rd);
    rot_c = (p_ext >= sc_q) ? p_ext - sc_q : p_ext + (na_q - sc_q);
    rot_u = (p_ext >= su_q) ? p_ext - su_q : p_ext + (nc_q - su_q);
    cu    = ra.nu;
    co    = ra.no;
    case (ra.lst)
      pcs_pkg::L_CZ: begin
        if (rot_c >= a_rem_q) begin
          cu = 1'b0;
          co = 1'b0;
        end
      end
      pcs_pkg::L_CN: begin
        if (p_ext >= b_rem_q) begin
          cu = 1'b0;
          co = 1'b0;
        end
      end
      pcs_pkg::L_UZ: begin
        if (optc_q && (rot_u == nc_q - CW'(1))) begin
          cu = 1'b1;
          co = 1'b1;
        end else if (rot_u >= c_rem_q) begin
          cu = 1'b1;
        end
      end
      pcs_pkg::L_UN: begin
        if (optd_q && (p_ext == nd_q - CW'(1))) begin
          cu = 1'b1;
          co = 1'b1;
        end else if (p_ext >= d_rem_q) begin
          cu = 1'b1;
        end
      end
      default: begin
      end
    endcase
    cchg = (cu != ra.ou) || (co != ra.oo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      cnt_q      <= '0;
      na_q       <= '0;
      nb_q       <= '0;
      nc_q       <= '0;
      nd_q       <= '0;
      a_rem_q    <= '0;
      b_rem_q    <= '0;
      c_rem_q    <= '0;
      d_rem_q    <= '0;
      sc_q       <= '0;
      su_q       <= '0;
      shc_q      <= '0;
      shu_q      <= '0;
      optn_q     <= 1'b1;
      optc_q     <= 1'b0;
      optd_q     <= 1'b0;
      unch_q     <= '0;
      i_q        <= '0;
      j_q        <= '0;
      pj_q       <= '0;
      rk_q       <= '0;
      pv_q       <= 1'b0;
      mstep_q    <= '0;
      mr_q       <= '0;
      msel_q     <= 1'b0;
      pend_v_q   <= 1'b0;
      pend_u_q   <= 1'b0;
      pend_o_q   <= 1'b0;
      pend_tag_q <= '0;
      cand_tag_q <= '0;
      cand_c_q   <= 1'b0;
      cand_u_q   <= 1'b0;
      cand_o_q   <= 1'b0;
      ov_q       <= 1'b0;
      ouser_q    <= 1'b0;
      olast_q    <= 1'b0;
      ounch_q    <= 1'b0;
      oopt_q     <= 1'b0;
      otag_q     <= '0;
    end else begin
      if (ov_q && m_tready_i && !ov_set) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_LOAD: begin
          if (pop) begin
            if (rec_we) begin
              cnt_q <= cnt_q + CW'(1);
              case (e_rec.lst)
                pcs_pkg::L_CZ: na_q <= na_q + CW'(1);
                pcs_pkg::L_CN: nb_q <= nb_q + CW'(1);
                pcs_pkg::L_UZ: nc_q <= nc_q + CW'(1);
                pcs_pkg::L_UN: nd_q <= nd_q + CW'(1);
                default: begin
                end
              endcase
            end
            if (q_data_i.last) begin
              shc_q  <= q_data_i.shuf_c;
              shu_q  <= q_data_i.shuf_u;
              optn_q <= q_data_i.optn;
              unch_q <= $signed(15'(q_data_i.ut));
              i_q    <= '0;
              if (cnt_q == '0 && !rec_we) begin
                state_q <= S_EE;
              end else begin
                state_q <= S_RI;
              end
            end
          end
        end
        S_RI: begin
          j_q     <= '0;
          rk_q    <= '0;
          pv_q    <= 1'b0;
          state_q <= S_RJ;
        end
        S_RJ: begin
          rk_q <= rank_fin;
          pv_q <= 1'b1;
          pj_q <= j_q;
          if (CW'(j_q) == cnt_q - CW'(1)) begin
            state_q <= S_RF;
          end else begin
            j_q <= j_q + AW'(1);
          end
        end
        S_RF: begin
          if (i_end) begin
            msel_q  <= 1'b0;
            mstep_q <= 4'd15;
            mr_q    <= '0;
            state_q <= S_MOD;
          end else begin
            i_q     <= i_q + AW'(1);
            state_q <= S_RI;
          end
        end
        S_MOD: begin
          if (mstep_q == 4'd0) begin
            mr_q <= '0;
            if (!msel_q) begin
              sc_q    <= (mod_n == '0) ? '0 : mod_r_d;
              msel_q  <= 1'b1;
              mstep_q <= 4'd15;
            end else begin
              su_q    <= (mod_n == '0) ? '0 : mod_r_d;
              state_q <= S_OPT;
            end
          end else begin
            mr_q    <= mod_r_d;
            mstep_q <= mstep_q - 4'd1;
          end
        end
        S_OPT: begin
          a_rem_q <= na_q;
          b_rem_q <= nb_q;
          c_rem_q <= opt_c ? nc_q - CW'(1) : nc_q;
          d_rem_q <= opt_d ? nd_q - CW'(1) : nd_q;
          optc_q  <= opt_c;
          optd_q  <= opt_d;
          state_q <= S_X1;
        end
        S_X1: begin
          a_rem_q <= a_rem_q - take;
          unch_q  <= unch_q - $signed(15'(take));
          state_q <= S_X2;
        end
        S_X2: begin
          b_rem_q <= b_rem_q - take;
          unch_q  <= unch_q - $signed(15'(take));
          state_q <= S_X3;
        end
        S_X3: begin
          d_rem_q <= d_rem_q - take;
          unch_q  <= unch_q + $signed(15'(take));
          state_q <= S_X4;
        end
        S_X4: begin
          c_rem_q <= c_rem_q - take;
          unch_q  <= unch_q + $signed(15'(take));
          state_q <= S_T5;
        end
        S_T5: begin
          a_rem_q <= a_rem_q - min_ad;
          d_rem_q <= d_rem_q - min_ad;
          state_q <= S_T6A;
        end
        S_T6A: begin
          if (b_rem_q == '0 || d_rem_q == '0) begin
            state_q <= S_T7;
          end else begin
            state_q <= S_T6C;
          end
        end
        S_T6C: begin
          if (unr_rd < cnr_rd) begin
            state_q <= S_T7;
          end else begin
            b_rem_q <= b_rem_q - CW'(1);
            d_rem_q <= d_rem_q - CW'(1);
            state_q <= S_T6A;
          end
        end
        S_T7: begin
          a_rem_q <= a_rem_q - min_ac;
          c_rem_q <= c_rem_q - min_ac;
          i_q     <= '0;
          state_q <= S_EA;
        end
        S_EA: begin
          state_q <= S_EW;
        end
        S_EW: begin
          cand_c_q   <= cchg;
          cand_u_q   <= cu;
          cand_o_q   <= co;
          cand_tag_q <= ra.tag;
          state_q    <= S_ED;
        end
        S_ED: begin
          if (!cand_c_q || !pend_v_q || out_free) begin
            if (cand_c_q) begin
              if (pend_v_q) begin
                ov_q    <= 1'b1;
                ouser_q <= 1'b1;
                olast_q <= 1'b0;
                otag_q  <= pend_tag_q;
                ounch_q <= pend_u_q;
                oopt_q  <= pend_o_q;
              end
              pend_v_q   <= 1'b1;
              pend_tag_q <= cand_tag_q;
              pend_u_q   <= cand_u_q;
              pend_o_q   <= cand_o_q;
            end
            if (i_end) begin
              state_q <= S_EE;
            end else begin
              i_q     <= i_q + AW'(1);
              state_q <= S_EA;
            end
          end
        end
        S_EE: begin
          if (out_free) begin
            ov_q     <= 1'b1;
            olast_q  <= 1'b1;
            ouser_q  <= pend_v_q;
            otag_q   <= pend_v_q ? pend_tag_q : '0;
            ounch_q  <= pend_v_q && pend_u_q;
            oopt_q   <= pend_v_q && pend_o_q;
            pend_v_q <= 1'b0;
            cnt_q    <= '0;
            na_q     <= '0;
            nb_q     <= '0;
            nc_q     <= '0;
            nd_q     <= '0;
            state_q  <= S_LOAD;
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  assign m_tvalid_o = ov_q;
  assign m_tuser_o  = ouser_q;
  assign m_tlast_o  = olast_q;
  assign m_tdata_o  = {6'b0, oopt_q, ounch_q, otag_q};

endmodule

FILE: hdl/peer_choke_scheduler_core.sv
// Peer choke scheduler top level: APB register, front end, queue and back end.
// Records load one per cycle; a pulse closes at the record with tlast.
// After the last record the back end ranks the stored records, reduces the
// shuffle values, trades slots, then walks the stored records to emit changes.
// Input is stalled while a pulse is being decided; the queue holds two records.
// Reset (async, low): empty store, counters cleared, unchoke_slots = 4242.
`include "peer_choke_scheduler_core_defines.svh"

module peer_choke_scheduler_core #(
  parameter int MaxPeers = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // APB configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // peer records
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: peer_tag, connected, interested, was_unchoked, was_optimistic,
  // last_change_ms, rate, now_ms, shuffle_choke, shuffle_unchoke, zero pad
  input  logic [183:0] s_axis_tdata,
  input  logic         s_axis_tlast,  // last_peer
  // decisions
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: out_tag, now_unchoked, now_optimistic, zero pad
  output logic [23:0]  m_axis_tdata,
  output logic         m_axis_tuser,  // valid_res
  output logic         m_axis_tlast   // last_result
);

  logic [pcs_pkg::SLOTS_W-1:0] slots_q;
  logic                        cfg_wr;
  logic                        q_in_valid, q_in_ready;
  logic                        q_out_valid, q_out_ready;
  pcs_pkg::qent_t              q_in_data, q_out_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == pcs_pkg::REG_UNCHOKE_SLOTS);
  assign prdata = (paddr[2] == pcs_pkg::REG_UNCHOKE_SLOTS) ? {19'b0, slots_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= pcs_pkg::SLOTS_RESET;
    end else if (cfg_wr) begin
      slots_q <= pwdata[pcs_pkg::SLOTS_W-1:0];
    end
  end

  pcs_front u_front (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_o(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tlast_i(s_axis_tlast),
    .q_valid_o(q_in_valid), .q_ready_i(q_in_ready), .q_data_o(q_in_data)
  );

  pcs_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(q_in_valid), .in_ready_o(q_in_ready), .in_data_i(q_in_data),
    .out_valid_o(q_out_valid), .out_ready_i(q_out_ready), .out_data_o(q_out_data)
  );

  pcs_back #(.MaxPeers(MaxPeers)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_out_valid), .q_ready_o(q_out_ready), .q_data_i(q_out_data),
    .slots_i(slots_q),
    .m_tvalid_o(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_o(m_axis_tdata), .m_tuser_o(m_axis_tuser), .m_tlast_o(m_axis_tlast)
  );

  `PCS_ASSERT_IMP(a_marker_last, m_axis_tvalid && !m_axis_tuser, m_axis_tlast, "marker not last")
  `PCS_ASSERT_IMP(a_marker_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 24'd0, "marker data")
  `PCS_ASSERT_IMP(a_opt_unch, m_axis_tvalid && m_axis_tdata[17], m_axis_tdata[16], "opt but choked")
  `PCS_ASSERT_NXT(a_cfg_hold, cfg_wr, slots_q == $past(pwdata[12:0]), "slot write lost")

endmodule
